### design/lbp_pkg.sv
`timescale 1ns / 1ps
// lbp_pkg: shared types, constants and command codes of the LSB-first bit packer.
// Used by lbp_core and lsb_first_bit_packer.
package lbp_pkg;

    localparam int STORE_BYTES    = 4096;
    localparam int ADDR_W         = $clog2(STORE_BYTES);
    localparam int MAX_FIELD_BITS = 64;
    localparam int CUR_W          = 16;
    localparam int LEN_W          = 13;
    localparam int CNT_W          = 7;
    localparam logic [CUR_W-1:0] CAP_BITS = CUR_W'(STORE_BYTES * 8);

    localparam logic [2:0] CMD_WRITE   = 3'd0;
    localparam logic [2:0] CMD_READ    = 3'd1;
    localparam logic [2:0] CMD_WRANGED = 3'd2;
    localparam logic [2:0] CMD_RRANGED = 3'd3;
    localparam logic [2:0] CMD_SETCUR  = 3'd4;
    localparam logic [2:0] CMD_CLEAR   = 3'd5;
    localparam logic [2:0] CMD_APPEND  = 3'd6;
    localparam logic [2:0] CMD_FETCH   = 3'd7;

    typedef struct packed {
        logic [2:0]         command;
        logic [63:0]        value;
        logic signed [31:0] ranged_value;
        logic [6:0]         bit_count;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
        logic [15:0]        position;
    } in_t;

    typedef struct packed {
        logic [63:0]        data_value;
        logic signed [31:0] ranged_result;
        logic [15:0]        cursor_bits;
        logic [15:0]        end_bits;
        logic [12:0]        length_bytes;
        logic               overflow;
    } out_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

endpackage

### design/lbp_store.sv
`timescale 1ns / 1ps
// lbp_store: generic byte RAM, one write and one registered read port.
// No package dependency.
module lbp_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/lbp_core.sv
`timescale 1ns / 1ps
// lbp_core: command sequencer; moves field bits one per cycle, pausing at each byte read, through a byte buffer.
// Depends on lbp_pkg; drives the byte store through a mem_req_t.
module lbp_core
    import lbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  in_t        item,
    output logic       idle,
    output logic       res_valid,
    input  logic       res_ready,
    output out_t       res,
    output mem_req_t   mreq,
    input  logic [7:0] rdata
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_WIDTH = 4'd1;
    localparam logic [3:0] ST_SETUP = 4'd2;
    localparam logic [3:0] ST_WRD   = 4'd3;
    localparam logic [3:0] ST_WWAIT = 4'd4;
    localparam logic [3:0] ST_WBIT  = 4'd5;
    localparam logic [3:0] ST_RRD   = 4'd6;
    localparam logic [3:0] ST_RWAIT = 4'd7;
    localparam logic [3:0] ST_RBIT  = 4'd8;
    localparam logic [3:0] ST_RFIN  = 4'd9;
    localparam logic [3:0] ST_FWAIT = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    logic [3:0]         state_reg, state_next;
    logic [2:0]         cmd_reg, cmd_next;
    logic [63:0]        val_reg, val_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [31:0] lo_reg, lo_next, hi_reg, hi_next, rv_reg, rv_next;
    logic [CUR_W-1:0]   cursor_reg, cursor_next, end_reg, end_next, p_reg, p_next;
    logic [LEN_W-1:0]   valid_reg, valid_next;
    logic [5:0]         idx_reg, idx_next;
    logic [63:0]        res_reg, res_next;
    logic signed [31:0] ranged_reg, ranged_next;
    logic               ovf_reg, ovf_next, at_end_reg, at_end_next;
    logic [7:0]         buf_reg, buf_next;
    logic [31:0]        tw_reg, tw_next;
    logic [5:0]         wid_reg, wid_next;

    logic [CUR_W-1:0]   pn;
    logic [7:0]         nb, fb;
    logic [CUR_W:0]     wend;
    logic [CUR_W-1:0]   avail;
    logic signed [31:0] clamped;
    logic signed [32:0] rsum;
    logic [LEN_W-1:0]   vinc, vneed;

    function automatic logic [7:0] low_mask8(input logic [2:0] k);
        return 8'hFF >> (4'd8 - {1'b0, k});
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cursor_reg <= '0;
            end_reg    <= '0;
            valid_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            end_reg    <= end_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        cnt_reg    <= cnt_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        rv_reg     <= rv_next;
        p_reg      <= p_next;
        idx_reg    <= idx_next;
        res_reg    <= res_next;
        ranged_reg <= ranged_next;
        ovf_reg    <= ovf_next;
        at_end_reg <= at_end_next;
        buf_reg    <= buf_next;
        tw_reg     <= tw_next;
        wid_reg    <= wid_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        val_next    = val_reg;
        cnt_next    = cnt_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        rv_next     = rv_reg;
        cursor_next = cursor_reg;
        end_next    = end_reg;
        valid_next  = valid_reg;
        p_next      = p_reg;
        idx_next    = idx_reg;
        res_next    = res_reg;
        ranged_next = ranged_reg;
        ovf_next    = ovf_reg;
        at_end_next = at_end_reg;
        buf_next    = buf_reg;
        tw_next     = tw_reg;
        wid_next    = wid_reg;
        mreq        = '0;

        pn      = p_reg + 1'b1;
        nb      = buf_reg;
        nb[p_reg[2:0]] = val_reg[0];
        fb      = nb;
        wend    = {1'b0, cursor_reg} + {{(CUR_W + 1 - CNT_W){1'b0}}, cnt_reg};
        avail   = (end_reg > cursor_reg) ? end_reg - cursor_reg : '0;
        clamped = (rv_reg < lo_reg) ? lo_reg : ((rv_reg > hi_reg) ? hi_reg : rv_reg);
        rsum    = {lo_reg[31], lo_reg} + {1'b0, res_reg[31:0]};
        vinc    = valid_reg + 1'b1;
        vneed   = LEN_W'(({1'b0, pn} + 17'd7) >> 3);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = item.command;
                    val_next    = item.value;
                    cnt_next    = (item.bit_count > CNT_W'(MAX_FIELD_BITS)) ?
                                  CNT_W'(MAX_FIELD_BITS) : item.bit_count;
                    lo_next     = item.range_low;
                    hi_next     = item.range_high;
                    rv_next     = item.ranged_value;
                    res_next    = '0;
                    ranged_next = '0;
                    ovf_next    = 1'b0;
                    state_next  = ST_DONE;
                    unique case (item.command)
                        CMD_WRITE, CMD_READ:
                        begin
                            state_next = ST_SETUP;
                        end
                        CMD_WRANGED, CMD_RRANGED:
                        begin
                            if (item.range_high > item.range_low)
                            begin
                                tw_next    = 32'(item.range_high - item.range_low);
                                wid_next   = '0;
                                state_next = ST_WIDTH;
                            end
                            else if (item.command == CMD_RRANGED)
                            begin
                                ranged_next = item.range_low;
                            end
                        end
                        CMD_SETCUR:
                        begin
                            cursor_next = (item.position > CAP_BITS) ? CAP_BITS : item.position;
                        end
                        CMD_CLEAR:
                        begin
                            cursor_next = '0;
                            end_next    = '0;
                            valid_next  = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (valid_reg >= LEN_W'(STORE_BYTES))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                mreq.wr_en   = 1'b1;
                                mreq.wr_addr = valid_reg[ADDR_W-1:0];
                                mreq.wr_data = item.value[7:0];
                                valid_next   = vinc;
                                end_next     = {vinc, 3'b000};
                            end
                        end
                        CMD_FETCH:
                        begin
                            if (item.position < {3'b000, valid_reg})
                            begin
                                mreq.rd_en   = 1'b1;
                                mreq.rd_addr = item.position[ADDR_W-1:0];
                                state_next   = ST_FWAIT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            // width = bit length of (high - low), one bit per cycle
            ST_WIDTH:
            begin
                if (tw_reg != '0)
                begin
                    tw_next  = tw_reg >> 1;
                    wid_next = wid_reg + 1'b1;
                end
                else
                begin
                    cnt_next   = {1'b0, wid_reg};
                    val_next   = {32'b0, 32'(clamped - lo_reg)};
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                p_next      = cursor_reg;
                idx_next    = '0;
                at_end_next = (cursor_reg == end_reg);
                if (cmd_reg == CMD_WRITE || cmd_reg == CMD_WRANGED)
                begin
                    if (cnt_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (wend > {1'b0, CAP_BITS})
                    begin
                        ovf_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_WRD;
                    end
                end
                else
                begin
                    if (avail < {{(CUR_W - CNT_W){1'b0}}, cnt_reg})
                    begin
                        cnt_next = avail[CNT_W-1:0];
                    end
                    if (cnt_reg == '0 || avail == '0)
                    begin
                        state_next = (cmd_reg == CMD_RRANGED) ? ST_RFIN : ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_RRD;
                    end
                end
            end
            ST_WRD:
            begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = p_reg[ADDR_W+2:3];
                state_next   = ST_WWAIT;
            end
            ST_WWAIT:
            begin
                buf_next   = rdata;
                state_next = ST_WBIT;
            end
            ST_WBIT:
            begin
                val_next = val_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                p_next   = pn;
                buf_next = nb;
                if (cnt_reg == CNT_W'(1))
                begin
                    // write starting at the end mark clears the rest of its last byte
                    if (at_end_reg && pn[2:0] != 3'd0)
                    begin
                        fb = nb & low_mask8(pn[2:0]);
                    end
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = p_reg[ADDR_W+2:3];
                    mreq.wr_data = fb;
                    cursor_next  = pn;
                    if (pn > end_reg)
                    begin
                        end_next = pn;
                    end
                    if (vneed > valid_reg)
                    begin
                        valid_next = vneed;
                    end
                    state_next = ST_DONE;
                end
                else if (pn[2:0] == 3'd0)
                begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = p_reg[ADDR_W+2:3];
                    mreq.wr_data = nb;
                    state_next   = ST_WRD;
                end
            end
            ST_RRD:
            begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = p_reg[ADDR_W+2:3];
                state_next   = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                buf_next   = rdata;
                state_next = ST_RBIT;
            end
            ST_RBIT:
            begin
                res_next[idx_reg] = buf_reg[p_reg[2:0]];
                idx_next = idx_reg + 1'b1;
                cnt_next = cnt_reg - 1'b1;
                p_next   = pn;
                if (cnt_reg == CNT_W'(1))
                begin
                    cursor_next = pn;
                    state_next  = (cmd_reg == CMD_RRANGED) ? ST_RFIN : ST_DONE;
                end
                else if (pn[2:0] == 3'd0)
                begin
                    state_next = ST_RRD;
                end
            end
            ST_RFIN:
            begin
                ranged_next = (rsum > $signed({hi_reg[31], hi_reg})) ? hi_reg : rsum[31:0];
                state_next  = ST_DONE;
            end
            ST_FWAIT:
            begin
                res_next   = {56'b0, rdata};
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb
    begin
        res.data_value    = res_reg;
        res.ranged_result = ranged_reg;
        res.cursor_bits   = cursor_reg;
        res.end_bits      = end_reg;
        res.length_bytes  = valid_reg;
        res.overflow      = ovf_reg;
    end

endmodule

### design/lsb_first_bit_packer.sv
`timescale 1ns / 1ps
// lsb_first_bit_packer: top level; command sequencer, byte store and output register.
// Depends on lbp_pkg, lbp_store and lbp_core.

// One word in, one word out per command. Plain and ranged fields move one bit per
// cycle, pausing at each byte read, through a byte buffer over a single-port-read
// byte store; a ranged field is first sized at one bit of high-low per cycle. Set
// cursor, clear and append are done in the idle state, and fetch reads one byte. A
// new word is taken as soon as the sequencer is idle, even while the previous result
// still waits in the output register.
module lsb_first_bit_packer
    import lbp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    logic       core_idle, res_valid, res_ready;
    out_t       res;
    mem_req_t   mreq;
    logic [7:0] rdata;
    logic       out_valid_reg;
    out_t       out_data_reg;

    lbp_store #(.DEPTH(STORE_BYTES)) u_store (
        .clk     (clk),
        .wr_en   (mreq.wr_en),
        .wr_addr (mreq.wr_addr),
        .wr_data (mreq.wr_data),
        .rd_en   (mreq.rd_en),
        .rd_addr (mreq.rd_addr),
        .rd_data (rdata)
    );

    lbp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid & core_idle),
        .item      (in_data),
        .idle      (core_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mreq      (mreq),
        .rdata     (rdata)
    );

    assign in_ready  = core_idle;
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for lsb_first_bit_packer; predicts each result word in-line.
// Depends on lbp_pkg and the lsb_first_bit_packer RTL.
module tb;
    import lbp_pkg::*;

    localparam int CAP      = STORE_BYTES * 8;
    localparam int IDLE_MAX = 6000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    lsb_first_bit_packer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // shadow of the packer state
    logic [7:0] shadow_store [STORE_BYTES];
    int         shadow_cur;
    int         shadow_end;
    int         shadow_len;

    in_t  cmd_queue [$];
    out_t result_queue [$];
    int   errors;
    int   words_in;
    int   idle_cycles;
    int   send_gap;
    int   recv_stall;
    bit   pressure_done;
    bit   quiet;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] low_mask(int n);
        if (n >= 64)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic int field_width(longint lo, longint hi);
        longint span;
        int     n;
        span = hi - lo + 1;
        n = 0;
        while (n < 40 && (longint'(1) << n) < span)
            n++;
        return (n > MAX_FIELD_BITS) ? MAX_FIELD_BITS : n;
    endfunction

    // returns 1 when the write is dropped for lack of room
    function automatic logic pack_bits(logic [63:0] v, int n);
        int s;
        int p;
        if (n == 0)
            return 1'b0;
        s = shadow_cur;
        if (s + n > CAP)
            return 1'b1;
        for (int i = 0; i < n; i++)
        begin
            p = s + i;
            shadow_store[p / 8][p % 8] = v[i];
        end
        shadow_cur = s + n;
        // writing at the end mark zeroes the rest of the last byte
        if (s == shadow_end && (shadow_cur % 8) != 0)
            for (int b = shadow_cur % 8; b < 8; b++)
                shadow_store[shadow_cur / 8][b] = 1'b0;
        if (shadow_cur > shadow_end)
            shadow_end = shadow_cur;
        if ((shadow_cur + 7) / 8 > shadow_len)
            shadow_len = (shadow_cur + 7) / 8;
        return 1'b0;
    endfunction

    function automatic logic [63:0] unpack_bits(int n);
        logic [63:0] r;
        int          avail;
        int          p;
        r = '0;
        avail = (shadow_end > shadow_cur) ? shadow_end - shadow_cur : 0;
        if (n > avail)
            n = avail;
        for (int i = 0; i < n; i++)
        begin
            p = shadow_cur + i;
            if (p < CAP)
                r[i] = shadow_store[p / 8][p % 8];
        end
        shadow_cur += n;
        return r;
    endfunction

    function automatic out_t packer_result(in_t w);
        out_t   o;
        int     cnt;
        int     n;
        longint lo;
        longint hi;
        longint c;
        longint s;
        lo = w.range_low;
        hi = w.range_high;
        cnt = (w.bit_count > MAX_FIELD_BITS) ? MAX_FIELD_BITS : int'(w.bit_count);
        o = '0;
        case (w.command)
            CMD_WRITE:
                o.overflow = pack_bits(w.value & low_mask(cnt), cnt);
            CMD_READ:
                o.data_value = unpack_bits(cnt);
            CMD_WRANGED:
                if (hi > lo)
                begin
                    c = w.ranged_value;
                    if (c < lo)
                        c = lo;
                    if (c > hi)
                        c = hi;
                    n = field_width(lo, hi);
                    o.overflow = pack_bits(64'(c - lo) & low_mask(n), n);
                end
            CMD_RRANGED:
                if (hi > lo)
                begin
                    o.data_value = unpack_bits(field_width(lo, hi));
                    s = lo + longint'(o.data_value[39:0]);
                    if (s > hi)
                        s = hi;
                    o.ranged_result = 32'(s);
                end
                else
                    o.ranged_result = w.range_low;
            CMD_SETCUR:
                shadow_cur = (int'(w.position) > CAP) ? CAP : int'(w.position);
            CMD_CLEAR:
            begin
                shadow_cur = 0;
                shadow_end = 0;
                shadow_len = 0;
            end
            CMD_APPEND:
                if (shadow_len >= STORE_BYTES)
                    o.overflow = 1'b1;
                else
                begin
                    shadow_store[shadow_len] = w.value[7:0];
                    shadow_len++;
                    shadow_end = shadow_len * 8;
                end
            default:
                if (int'(w.position) < shadow_len)
                    o.data_value = {56'd0, shadow_store[w.position]};
        endcase
        o.cursor_bits  = 16'(shadow_cur);
        o.end_bits     = 16'(shadow_end);
        o.length_bytes = 13'(shadow_len);
        return o;
    endfunction

    task automatic add_cmd(logic [2:0] cmd, logic [63:0] v, int rv, int cnt,
                           int lo, int hi, int pos);
        in_t w;
        w.command      = cmd;
        w.value        = v;
        w.ranged_value = rv;
        w.bit_count    = 7'(cnt);
        w.range_low    = lo;
        w.range_high   = hi;
        w.position     = 16'(pos);
        cmd_queue.push_back(w);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // bounds: mostly narrow spans, some full-width, some empty or reversed
    task automatic pick_range(output int lo, output int hi);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            lo = int'($urandom_range(0, 2000000)) - 1000000;
            hi = lo + int'($urandom_range(1, (r < 3) ? 20 : 70000));
        end
        else if (r < 8)
        begin
            lo = $urandom;
            hi = $urandom;
        end
        else
        begin
            lo = $urandom;
            hi = lo;
        end
    endtask

    task automatic noise_cmd();
        int lo;
        int hi;
        int r;
        pick_range(lo, hi);
        r = $urandom_range(0, 99);
        add_cmd(3'($urandom_range(0, 7)), rand64(), $urandom,
                (r < 10) ? $urandom_range(65, 127) : $urandom_range(0, 64),
                lo, hi,
                (r < 80) ? $urandom_range(0, 4200) : $urandom_range(0, 65535));
    endtask

    task automatic round_trip();
        int          x;
        int          k;
        int          cnts [8];
        int          los [8];
        int          his [8];
        bit          rng [8];
        logic [63:0] v;
        x = $urandom_range(0, 3000);
        k = $urandom_range(1, 8);
        add_cmd(CMD_SETCUR, rand64(), 0, 0, 0, 0, x);
        for (int j = 0; j < k; j++)
        begin
            rng[j]  = ($urandom_range(0, 2) == 0);
            cnts[j] = $urandom_range(0, 64);
            pick_range(los[j], his[j]);
            v = rand64();
            if (rng[j])
                add_cmd(CMD_WRANGED, v, $urandom, 0, los[j], his[j], 0);
            else
                add_cmd(CMD_WRITE, v, 0, cnts[j], 0, 0, 0);
        end
        add_cmd(CMD_SETCUR, 0, 0, 0, 0, 0, x);
        for (int j = 0; j < k; j++)
            if (rng[j])
                add_cmd(CMD_RRANGED, rand64(), $urandom, 0, los[j], his[j], 0);
            else
                add_cmd(CMD_READ, rand64(), 0, cnts[j], 0, 0, 0);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        logic take;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap = 0;
        end
        else
        begin
            take = in_valid && in_ready;
            if (take)
            begin
                result_queue.push_back(packer_result(in_data));
                words_in++;
                send_gap = pick_gap();
            end
            if (!in_valid || take)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (cmd_queue.size() > 0)
                begin
                    in_data  <= cmd_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        out_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (result_queue.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    e = result_queue.pop_front();
                    if (out_data.data_value !== e.data_value)
                    begin
                        $error("data_value exp %h got %h", e.data_value, out_data.data_value);
                        errors++;
                    end
                    if (out_data.ranged_result !== e.ranged_result)
                    begin
                        $error("ranged_result exp %0d got %0d", e.ranged_result,
                               out_data.ranged_result);
                        errors++;
                    end
                    if (out_data.cursor_bits !== e.cursor_bits)
                    begin
                        $error("cursor_bits exp %0d got %0d", e.cursor_bits,
                               out_data.cursor_bits);
                        errors++;
                    end
                    if (out_data.end_bits !== e.end_bits)
                    begin
                        $error("end_bits exp %0d got %0d", e.end_bits, out_data.end_bits);
                        errors++;
                    end
                    if (out_data.length_bytes !== e.length_bytes)
                    begin
                        $error("length_bytes exp %0d got %0d", e.length_bytes,
                               out_data.length_bytes);
                        errors++;
                    end
                    if (out_data.overflow !== e.overflow)
                    begin
                        $error("overflow exp %0d got %0d", e.overflow, out_data.overflow);
                        errors++;
                    end
                end
                recv_stall = pick_gap();
            end
            // one long hold-off so the packer backs up into its input
            if (!pressure_done && words_in >= 700)
            begin
                pressure_done = 1'b1;
                recv_stall = 400;
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && $urandom_range(0, 199) == 0)
            quiet <= ~quiet;
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_MAX)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int n_rand;
        errors        = 0;
        words_in      = 0;
        idle_cycles   = 0;
        pressure_done = 1'b0;
        quiet         = 1'b0;
        shadow_cur    = 0;
        shadow_end    = 0;
        shadow_len    = 0;
        rst_n         = 1'b0;

        // preload: fill the whole store so no unwritten bit is ever read
        for (int i = 0; i < CAP / 64; i++)
            add_cmd(CMD_WRITE, rand64(), 0, 64, 0, 0, 0);

        add_cmd(CMD_APPEND, 64'hFF, 0, 0, 0, 0, 0);               // store full
        add_cmd(CMD_FETCH, 0, 0, 0, 0, 0, 0);
        add_cmd(CMD_FETCH, 0, 0, 0, 0, 0, STORE_BYTES - 1);
        add_cmd(CMD_FETCH, 0, 0, 0, 0, 0, STORE_BYTES);
        add_cmd(CMD_FETCH, 0, 0, 0, 0, 0, 16'hFFFF);
        add_cmd(CMD_SETCUR, 0, 0, 0, 0, 0, 16'hFFFF);             // saturates
        add_cmd(CMD_WRITE, '1, 0, 1, 0, 0, 0);                    // no room
        add_cmd(CMD_READ, 0, 0, 64, 0, 0, 0);                     // at the end
        add_cmd(CMD_SETCUR, 0, 0, 0, 0, 0, CAP - 8);
        add_cmd(CMD_WRITE, 64'h5A, 0, 8, 0, 0, 0);                // fits exactly
        add_cmd(CMD_SETCUR, 0, 0, 0, 0, 0, CAP - 8);
        add_cmd(CMD_WRITE, '1, 0, 9, 0, 0, 0);                    // one bit too many
        add_cmd(CMD_SETCUR, 0, 0, 0, 0, 0, CAP - 40);
        add_cmd(CMD_READ, 0, 0, 127, 0, 0, 0);                    // cut at end
        add_cmd(CMD_SETCUR, 0, 0, 0, 0, 0, 100);
        add_cmd(CMD_READ, 0, 0, 0, 0, 0, 0);
        add_cmd(CMD_WRITE, '1, 0, 0, 0, 0, 0);
        add_cmd(CMD_WRANGED, 0, 7, 0, 5, 5, 0);                   // empty range
        add_cmd(CMD_RRANGED, 0, 0, 0, 9, 3, 0);                   // reversed range
        add_cmd(CMD_WRANGED, 0, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        add_cmd(CMD_WRANGED, 0, 1000, 0, -10, 10, 0);             // clamped high
        add_cmd(CMD_SETCUR, 0, 0, 0, 0, 0, 100);
        add_cmd(CMD_RRANGED, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        add_cmd(CMD_RRANGED, 0, 0, 0, -10, 10, 0);
        add_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
        add_cmd(CMD_APPEND, 64'h1234_5678_9ABC_DEA5, 0, 0, 0, 0, 0);
        add_cmd(CMD_APPEND, 64'h3C, 0, 0, 0, 0, 0);
        add_cmd(CMD_SETCUR, 0, 0, 0, 0, 0, 16);
        add_cmd(CMD_WRITE, 64'h5, 0, 3, 0, 0, 0);                 // at end mark
        add_cmd(CMD_FETCH, 0, 0, 0, 0, 0, 2);

        n_rand = 0;
        while (n_rand < 400)
        begin
            if ($urandom_range(0, 99) < 70)
                round_trip();
            else
                noise_cmd();
            n_rand = cmd_queue.size() - CAP / 64 - 30;
        end

        repeat (3) @(posedge clk);
        rst_n = 1'b1;

        while (cmd_queue.size() > 0 || in_valid)
            @(posedge clk);
        while (result_queue.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (errors == 0 && out_valid !== 1'b1)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
